// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SLTP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define SLTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/sltp_pkg.sv =====
// ----------------------------------------------------------------------------
// sltp_pkg
// Types, constants and helpers for the sphere / line target point pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sltp_pkg;

    // coordinate format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int RAD_W     = 31;
    localparam int UNIT_BITS = 30;

    // 0.01 rounded to the coordinate format
    localparam logic [RAD_W-1:0] MIN_LEN_RESET = RAD_W'(((1 << FRAC_BITS) + 50) / 100);

    // pipeline stage map
    localparam int ROOT_BITS = 31;
    localparam int S_IN      = 0;
    localparam int S_SQ      = 1;
    localparam int S_SUM     = 2;
    localparam int S_MSQ     = 3;
    localparam int S_L2S     = 4;
    localparam int S_R1      = 5;
    localparam int S_DINIT   = S_R1 + ROOT_BITS;
    localparam int S_DV1     = S_DINIT + 1;
    localparam int S_PW      = S_DV1 + ROOT_BITS;
    localparam int S_PA      = S_PW + 1;
    localparam int S_PD      = S_PA + 1;
    localparam int S_DD      = S_PD + 1;
    localparam int S_CD      = S_DD + 1;
    localparam int S_CSQ     = S_CD + 1;
    localparam int S_CDS     = S_CSQ + 1;
    localparam int S_H1      = S_CDS + 1;
    localparam int S_PH      = S_H1 + ROOT_BITS;
    localparam int S_T       = S_PH + 1;
    localparam int N_STAGES  = S_T + 1;

    // one item as it travels down the pipeline
    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [2:0][31:0] c;
        logic [30:0]      rad;
        logic [2:0][32:0] u;
        logic [2:0][32:0] w;
        logic [2:0][32:0] v;
        logic [2:0][32:0] umag;
        logic [32:0]      mx;
        logic [61:0]      mm;
        logic             degen;
        logic [2:0][29:0] m;
        logic [2:0][75:0] prod;
        logic [2:0][63:0] prod2;
        logic [62:0]      sqrem;
        logic [30:0]      root;
        logic [2:0][60:0] drem;
        logic [2:0][30:0] q;
        logic [35:0]      pa;
        logic [35:0]      pb;
        logic [2:0][36:0] d;
        logic [2:0][37:0] cd;
        logic [61:0]      rs;
        logic             hit;
        logic [2:0][31:0] t;
    } item_t;

    // drop UNIT_BITS fraction bits, rounding half away from zero on a magnitude
    function automatic logic [45:0] round_unit(input logic [75:0] p);
        logic [76:0] s;
        s = {1'b0, p} + 77'(1 << (UNIT_BITS - 1));
        return s[75:30];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sltp_req_if.sv =====
// ----------------------------------------------------------------------------
// sltp_req_if / sltp_res_if
// Valid/ready channels for requests (sphere and segment) and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sltp_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] center_z;
    logic [30:0] radius;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [31:0] end_z;

    modport source (output valid, center_x, center_y, center_z, radius, start_x, start_y,
                    start_z, end_x, end_y, end_z, input ready);
    modport sink   (input valid, center_x, center_y, center_z, radius, start_x, start_y,
                    start_z, end_x, end_y, end_z, output ready);
endinterface

interface sltp_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] target_z;
    logic        hit;
    logic        degenerate;

    modport source (output valid, target_x, target_y, target_z, hit, degenerate, input ready);
    modport sink   (input valid, target_x, target_y, target_z, hit, degenerate, output ready);
endinterface

`default_nettype wire

// ===== rtl/sphere_line_target_point_core.sv =====
// ----------------------------------------------------------------------------
// sphere_line_target_point_core
// Picks a target point on segment A->B against a sphere (C, r), Q16.16.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_in    in   valid/ready    center, radius, start, end
//  res_out   out  valid/ready    target_x/y/z, hit, degenerate
//  cfg       in   cfg_wr_en      cfg_wr_data = min_segment_length
//
//  one request per cycle while not frozen, through 108 register stages; most of
//  the depth comes from three one-bit-per-stage units (segment length root,
//  direction divide, chord root)
//  reset clears the valid bits and loads min_segment_length with 655
//  a result not taken freezes the whole pipeline, including req_in.ready
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_line_target_point_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [30:0] cfg_wr_data,
    sltp_req_if.sink         req_in,
    sltp_res_if.source       res_out
);

    localparam int N    = sltp_pkg::N_STAGES;
    localparam int LAST = N - 1;

    logic [30:0]         min_len_reg;
    logic [N-1:0]        vld_reg;
    sltp_pkg::item_t     pipe_reg  [N];
    sltp_pkg::item_t     pipe_next [N];
    logic                en;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= sltp_pkg::MIN_LEN_RESET;
        else if (cfg_wr_en)
            min_len_reg <= cfg_wr_data;
    end

    // global advance: move when the output slot is free or being taken
    assign en           = !vld_reg[LAST] || res_out.ready;
    assign req_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], req_in.valid};
    end

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            // payload register of this stage
            always_ff @(posedge clk)
            begin
                if (en)
                    pipe_reg[s] <= pipe_next[s];
            end

            if (s == sltp_pkg::S_IN)
            begin : g_in
                // capture and form differences
                always_comb
                begin
                    pipe_next[s]      = '0;
                    pipe_next[s].c[0] = req_in.center_x;
                    pipe_next[s].c[1] = req_in.center_y;
                    pipe_next[s].c[2] = req_in.center_z;
                    pipe_next[s].a[0] = req_in.start_x;
                    pipe_next[s].a[1] = req_in.start_y;
                    pipe_next[s].a[2] = req_in.start_z;
                    pipe_next[s].b[0] = req_in.end_x;
                    pipe_next[s].b[1] = req_in.end_y;
                    pipe_next[s].b[2] = req_in.end_z;
                    pipe_next[s].rad  = req_in.radius;
                    for (int i = 0; i < 3; i++)
                    begin
                        pipe_next[s].u[i] = {pipe_next[s].b[i][31], pipe_next[s].b[i]}
                                          - {pipe_next[s].a[i][31], pipe_next[s].a[i]};
                        pipe_next[s].w[i] = {pipe_next[s].c[i][31], pipe_next[s].c[i]}
                                          - {pipe_next[s].a[i][31], pipe_next[s].a[i]};
                        pipe_next[s].v[i] = {pipe_next[s].c[i][31], pipe_next[s].c[i]}
                                          - {pipe_next[s].b[i][31], pipe_next[s].b[i]};
                    end
                end
            end
            else if (s == sltp_pkg::S_SQ)
            begin : g_sq
                logic [65:0] sq [3];
                // magnitudes, squares and threshold square
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        pipe_next[s].umag[i] = pipe_reg[s-1].u[i][32] ? -pipe_reg[s-1].u[i]
                                                                     : pipe_reg[s-1].u[i];
                        sq[i] = pipe_next[s].umag[i] * pipe_next[s].umag[i];
                        pipe_next[s].prod[i] = 76'(sq[i]);
                    end
                    pipe_next[s].mx = pipe_next[s].umag[0];
                    if (pipe_next[s].umag[1] > pipe_next[s].mx)
                        pipe_next[s].mx = pipe_next[s].umag[1];
                    if (pipe_next[s].umag[2] > pipe_next[s].mx)
                        pipe_next[s].mx = pipe_next[s].umag[2];
                    pipe_next[s].mm = min_len_reg * min_len_reg;
                end
            end
            else if (s == sltp_pkg::S_SUM)
            begin : g_sum
                logic [67:0] l2;
                // length test and normalizing shift
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    l2 = 68'(pipe_reg[s-1].prod[0][65:0]) + 68'(pipe_reg[s-1].prod[1][65:0])
                       + 68'(pipe_reg[s-1].prod[2][65:0]);
                    pipe_next[s].degen = (pipe_reg[s-1].mx == '0) || (l2 < 68'(pipe_reg[s-1].mm));
                    for (int i = 0; i < 3; i++)
                    begin
                        priority if (pipe_reg[s-1].mx[32])
                            pipe_next[s].m[i] = 30'(pipe_reg[s-1].umag[i] >> 3);
                        else if (pipe_reg[s-1].mx[31])
                            pipe_next[s].m[i] = 30'(pipe_reg[s-1].umag[i] >> 2);
                        else if (pipe_reg[s-1].mx[30])
                            pipe_next[s].m[i] = 30'(pipe_reg[s-1].umag[i] >> 1);
                        else
                            pipe_next[s].m[i] = pipe_reg[s-1].umag[i][29:0];
                    end
                end
            end
            else if (s == sltp_pkg::S_MSQ)
            begin : g_msq
                logic [59:0] sq [3];
                // squares of the shifted direction
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        sq[i] = pipe_reg[s-1].m[i] * pipe_reg[s-1].m[i];
                        pipe_next[s].prod[i] = 76'(sq[i]);
                    end
                end
            end
            else if (s == sltp_pkg::S_L2S)
            begin : g_l2s
                // sum feeds the length root
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    pipe_next[s].sqrem = 63'(pipe_reg[s-1].prod[0][59:0])
                                       + 63'(pipe_reg[s-1].prod[1][59:0])
                                       + 63'(pipe_reg[s-1].prod[2][59:0]);
                    pipe_next[s].root  = '0;
                end
            end
            else if ((s >= sltp_pkg::S_R1 && s < sltp_pkg::S_DINIT)
                  || (s >= sltp_pkg::S_H1 && s < sltp_pkg::S_PH))
            begin : g_root
                localparam int BIT = (s < sltp_pkg::S_DINIT)
                                   ? (sltp_pkg::ROOT_BITS - 1 - (s - sltp_pkg::S_R1))
                                   : (sltp_pkg::ROOT_BITS - 1 - (s - sltp_pkg::S_H1));
                logic [62:0] trial;
                // one root bit: try root + 2^BIT against the remainder
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    trial = (63'(pipe_reg[s-1].root) << (BIT + 1)) + (63'(1) << (2 * BIT));
                    if (pipe_reg[s-1].sqrem >= trial)
                    begin
                        pipe_next[s].sqrem     = pipe_reg[s-1].sqrem - trial;
                        pipe_next[s].root[BIT] = 1'b1;
                    end
                end
            end
            else if (s == sltp_pkg::S_DINIT)
            begin : g_dinit
                // rounded dividend for the unit direction
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        pipe_next[s].drem[i] = (61'(pipe_reg[s-1].m[i]) << sltp_pkg::UNIT_BITS)
                                             + 61'(pipe_reg[s-1].root >> 1);
                        pipe_next[s].q[i]    = '0;
                    end
                end
            end
            else if (s >= sltp_pkg::S_DV1 && s < sltp_pkg::S_PW)
            begin : g_div
                localparam int BIT = sltp_pkg::ROOT_BITS - 1 - (s - sltp_pkg::S_DV1);
                logic [60:0] trial;
                // one quotient bit in each lane
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    trial = 61'(pipe_reg[s-1].root) << BIT;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (pipe_reg[s-1].drem[i] >= trial)
                        begin
                            pipe_next[s].drem[i]   = pipe_reg[s-1].drem[i] - trial;
                            pipe_next[s].q[i][BIT] = 1'b1;
                        end
                    end
                end
            end
            else if (s == sltp_pkg::S_PW)
            begin : g_pw
                logic [32:0] wm [3];
                logic [32:0] vm [3];
                // projections of C-A and C-B onto n
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        wm[i] = pipe_reg[s-1].w[i][32] ? -pipe_reg[s-1].w[i] : pipe_reg[s-1].w[i];
                        vm[i] = pipe_reg[s-1].v[i][32] ? -pipe_reg[s-1].v[i] : pipe_reg[s-1].v[i];
                        pipe_next[s].prod[i]  = 76'(wm[i] * pipe_reg[s-1].q[i]);
                        pipe_next[s].prod2[i] = 64'(vm[i] * pipe_reg[s-1].q[i]);
                    end
                end
            end
            else if (s == sltp_pkg::S_PA)
            begin : g_pa
                logic [45:0] rw [3];
                logic [45:0] rv [3];
                logic [35:0] tw [3];
                logic [35:0] tv [3];
                // signed dot products
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        rw[i] = sltp_pkg::round_unit(pipe_reg[s-1].prod[i]);
                        rv[i] = sltp_pkg::round_unit(76'(pipe_reg[s-1].prod2[i]));
                        tw[i] = (pipe_reg[s-1].w[i][32] ^ pipe_reg[s-1].u[i][32])
                              ? -rw[i][35:0] : rw[i][35:0];
                        tv[i] = (pipe_reg[s-1].v[i][32] ^ pipe_reg[s-1].u[i][32])
                              ? -rv[i][35:0] : rv[i][35:0];
                    end
                    pipe_next[s].pa = tw[0] + tw[1] + tw[2];
                    pipe_next[s].pb = tv[0] + tv[1] + tv[2];
                end
            end
            else if (s == sltp_pkg::S_PD)
            begin : g_pd
                logic [35:0] pm;
                // n times the projection onto the line
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    pm = pipe_reg[s-1].pa[35] ? -pipe_reg[s-1].pa : pipe_reg[s-1].pa;
                    for (int i = 0; i < 3; i++)
                        pipe_next[s].prod[i] = 76'(pm * pipe_reg[s-1].q[i]);
                end
            end
            else if (s == sltp_pkg::S_DD)
            begin : g_dd
                logic [45:0] r [3];
                logic [36:0] tm [3];
                // foot point D
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        r[i]  = sltp_pkg::round_unit(pipe_reg[s-1].prod[i]);
                        tm[i] = (pipe_reg[s-1].u[i][32] ^ pipe_reg[s-1].pa[35])
                              ? -r[i][36:0] : r[i][36:0];
                        pipe_next[s].d[i] = {{5{pipe_reg[s-1].a[i][31]}}, pipe_reg[s-1].a[i]}
                                          + tm[i];
                    end
                end
            end
            else if (s == sltp_pkg::S_CD)
            begin : g_cd
                // offset from centre to foot
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                        pipe_next[s].cd[i] = {{6{pipe_reg[s-1].c[i][31]}}, pipe_reg[s-1].c[i]}
                                           - {pipe_reg[s-1].d[i][36], pipe_reg[s-1].d[i]};
                end
            end
            else if (s == sltp_pkg::S_CSQ)
            begin : g_csq
                logic [37:0] cm [3];
                // squared distance terms and squared radius
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                    begin
                        cm[i] = pipe_reg[s-1].cd[i][37] ? -pipe_reg[s-1].cd[i] : pipe_reg[s-1].cd[i];
                        pipe_next[s].prod[i] = cm[i] * cm[i];
                    end
                    pipe_next[s].rs = pipe_reg[s-1].rad * pipe_reg[s-1].rad;
                end
            end
            else if (s == sltp_pkg::S_CDS)
            begin : g_cds
                logic [77:0] cds;
                logic [77:0] diff;
                // crossing test, chord remainder feeds the second root
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    cds  = 78'(pipe_reg[s-1].prod[0]) + 78'(pipe_reg[s-1].prod[1])
                         + 78'(pipe_reg[s-1].prod[2]);
                    diff = 78'(pipe_reg[s-1].rs) - cds;
                    pipe_next[s].hit   = 78'(pipe_reg[s-1].rs) > cds;
                    pipe_next[s].sqrem = pipe_next[s].hit ? diff[62:0] : '0;
                    pipe_next[s].root  = '0;
                end
            end
            else if (s == sltp_pkg::S_PH)
            begin : g_ph
                // n times the chord half-length
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    for (int i = 0; i < 3; i++)
                        pipe_next[s].prod[i] = 76'(pipe_reg[s-1].q[i] * pipe_reg[s-1].root);
                end
            end
            else
            begin : g_t
                logic [45:0] r   [3];
                logic [37:0] tm  [3];
                logic [37:0] th  [3];
                logic [37:0] sel [3];
                logic        past_b;
                logic        before_a;
                // pick, saturate and flag
                always_comb
                begin
                    pipe_next[s] = pipe_reg[s-1];
                    past_b   = !pipe_reg[s-1].pb[35] && (pipe_reg[s-1].pb != '0);
                    before_a = pipe_reg[s-1].pa[35];
                    for (int i = 0; i < 3; i++)
                    begin
                        r[i]  = sltp_pkg::round_unit(pipe_reg[s-1].prod[i]);
                        tm[i] = pipe_reg[s-1].u[i][32] ? -r[i][37:0] : r[i][37:0];
                        th[i] = {pipe_reg[s-1].d[i][36], pipe_reg[s-1].d[i]} + tm[i];
                        priority if (pipe_reg[s-1].degen)
                            sel[i] = '0;
                        else if (past_b)
                            sel[i] = {{6{pipe_reg[s-1].b[i][31]}}, pipe_reg[s-1].b[i]};
                        else if (pipe_reg[s-1].hit)
                            sel[i] = th[i];
                        else if (before_a)
                            sel[i] = {{6{pipe_reg[s-1].a[i][31]}}, pipe_reg[s-1].a[i]};
                        else
                            sel[i] = {pipe_reg[s-1].d[i][36], pipe_reg[s-1].d[i]};
                        priority if (!sel[i][37] && (sel[i][36:31] != '0))
                            pipe_next[s].t[i] = {1'b0, {31{1'b1}}};
                        else if (sel[i][37] && (sel[i][36:31] != '1))
                            pipe_next[s].t[i] = {1'b1, {31{1'b0}}};
                        else
                            pipe_next[s].t[i] = sel[i][31:0];
                    end
                    pipe_next[s].hit = pipe_reg[s-1].degen || pipe_reg[s-1].hit;
                end
            end
        end
    endgenerate

    // result port
    assign res_out.valid      = vld_reg[LAST];
    assign res_out.target_x   = pipe_reg[LAST].t[0];
    assign res_out.target_y   = pipe_reg[LAST].t[1];
    assign res_out.target_z   = pipe_reg[LAST].t[2];
    assign res_out.hit        = pipe_reg[LAST].hit;
    assign res_out.degenerate = pipe_reg[LAST].degen;

endmodule

`default_nettype wire

// ===== rtl/sltp_checker.sv =====
// ----------------------------------------------------------------------------
// sltp_checker
// Port-level checks on the target point core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sltp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] tx,
    input wire logic [31:0] ty,
    input wire logic [31:0] tz,
    input wire logic        hit,
    input wire logic        degenerate
);

    // a degenerate segment always reports a hit
    `SLTP_ASSERT_IMPL(a_degen_hit, clk, rst_n, out_valid && degenerate, hit)

    // a degenerate segment reports the zero point
    `SLTP_ASSERT_IMPL(a_degen_zero, clk, rst_n, out_valid && degenerate,
                      tx == '0 && ty == '0 && tz == '0)

    // an empty output slot never blocks requests
    `SLTP_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)

    // a held result keeps its fields
    `SLTP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
                      out_valid && $stable(tx) && $stable(ty) && $stable(tz) && $stable(hit))

endmodule

bind sphere_line_target_point_core sltp_checker u_sltp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (req_in.ready),
    .out_valid  (res_out.valid),
    .out_ready  (res_out.ready),
    .tx         (res_out.target_x),
    .ty         (res_out.target_y),
    .tz         (res_out.target_z),
    .hit        (res_out.hit),
    .degenerate (res_out.degenerate)
);

`default_nettype wire

// ===== tb/tb_sphere_line_target_point_core.sv =====
// ----------------------------------------------------------------------------
// tb_sphere_line_target_point_core
// Checks the sphere / segment target point pipeline against a predictor
// in the testbench: directed geometry, threshold settings and random
// requests, with idle cycles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sphere_line_target_point_core;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 130;
    localparam logic [30:0] LEN_MAX = 31'h7fff_ffff;

    typedef struct {
        logic [2:0][31:0] ctr;
        logic [30:0]      rad;
        logic [2:0][31:0] pa;
        logic [2:0][31:0] pb;
    } query_t;

    typedef struct {
        logic [2:0][31:0] tgt;
        logic             hit;
        logic             degen;
    } target_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [30:0] cfg_wr_data;

    sltp_req_if req_ch ();
    sltp_res_if res_ch ();

    sphere_line_target_point_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_in      (req_ch.sink),
        .res_out     (res_ch.source)
    );

    target_t     pending_targets[$];
    logic [30:0] min_len_model;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          quiet_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] floor_root(input logic [127:0] x);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // product with a Q1.30 unit value, rounded half away from zero
    function automatic longint unit_product(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0]  lo;
        logic         neg;
        neg = (a < 0) != (b < 0);
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)}
          + (128'd1 << (sltp_pkg::UNIT_BITS - 1));
        if ((p >> sltp_pkg::UNIT_BITS) > 128'h7fff_ffff_ffff_ffff)
            lo = 64'h7fff_ffff_ffff_ffff;
        else
            lo = p[sltp_pkg::UNIT_BITS +: 64];
        return neg ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic logic [31:0] clamp_coord(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic target_t predict_target(input query_t q, input logic [30:0] min_len);
        target_t      res;
        longint       c[3], a[3], b[3], u[3], w[3], v[3], n[3], d[3], t[3];
        logic [127:0] seg_sq, cd_sq, r_sq, lim_sq;
        logic [63:0]  mx, m, sq_scaled, len, qv, h;
        longint       proj_a, proj_b, cd;
        int           k;
        seg_sq = '0;
        cd_sq = '0;
        mx = '0;
        sq_scaled = '0;
        proj_a = 0;
        proj_b = 0;
        k = 0;
        res.degen = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = longint'(signed'(q.ctr[i]));
            a[i] = longint'(signed'(q.pa[i]));
            b[i] = longint'(signed'(q.pb[i]));
            u[i] = b[i] - a[i];
            w[i] = c[i] - a[i];
            v[i] = c[i] - b[i];
            seg_sq += {64'd0, magnitude(u[i])} * {64'd0, magnitude(u[i])};
            if (magnitude(u[i]) > mx)
                mx = magnitude(u[i]);
        end
        lim_sq = {97'd0, min_len} * {97'd0, min_len};
        // short or zero segment
        if (mx == 0 || lim_sq > seg_sq)
        begin
            res.tgt = '0;
            res.hit = 1'b1;
            res.degen = 1'b1;
            return res;
        end
        // unit direction in Q1.30
        while ((mx >> k) >= (64'd1 << sltp_pkg::UNIT_BITS))
            k++;
        for (int i = 0; i < 3; i++)
        begin
            m = magnitude(u[i]) >> k;
            sq_scaled += m * m;
        end
        len = floor_root({64'd0, sq_scaled});
        for (int i = 0; i < 3; i++)
        begin
            m = magnitude(u[i]) >> k;
            qv = ((m << sltp_pkg::UNIT_BITS) + len / 2) / len;
            n[i] = u[i] < 0 ? -longint'(qv) : longint'(qv);
        end
        for (int i = 0; i < 3; i++)
        begin
            proj_a += unit_product(w[i], n[i]);
            proj_b += unit_product(v[i], n[i]);
        end
        // foot of the centre on the line
        for (int i = 0; i < 3; i++)
        begin
            d[i] = a[i] + unit_product(n[i], proj_a);
            cd = c[i] - d[i];
            cd_sq += {64'd0, magnitude(cd)} * {64'd0, magnitude(cd)};
        end
        r_sq = {97'd0, q.rad} * {97'd0, q.rad};
        res.hit = r_sq > cd_sq;
        if (res.hit)
        begin
            h = floor_root(r_sq - cd_sq);
            for (int i = 0; i < 3; i++)
                t[i] = proj_b > 0 ? b[i] : d[i] + unit_product(n[i], longint'(h));
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                t[i] = d[i];
                if (proj_a < 0) t[i] = a[i];
                if (proj_b > 0) t[i] = b[i];
            end
        end
        for (int i = 0; i < 3; i++)
            res.tgt[i] = clamp_coord(t[i]);
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_request(input query_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.center_x <= q.ctr[0];
        req_ch.center_y <= q.ctr[1];
        req_ch.center_z <= q.ctr[2];
        req_ch.radius   <= q.rad;
        req_ch.start_x  <= q.pa[0];
        req_ch.start_y  <= q.pa[1];
        req_ch.start_z  <= q.pa[2];
        req_ch.end_x    <= q.pb[0];
        req_ch.end_y    <= q.pb[1];
        req_ch.end_z    <= q.pb[2];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_targets.push_back(predict_target(q, min_len_model));
    endtask

    // wait for every result, then let the pipeline empty
    task automatic drain_pipeline();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_targets.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_length(input logic [30:0] val);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        min_len_model = val;
    endtask

    function automatic query_t make_query(input logic [31:0] cx, cy, cz, input logic [30:0] r,
                                          input logic [31:0] ax, ay, az, bx, by, bz);
        query_t q;
        q.ctr = {cz, cy, cx};
        q.rad = r;
        q.pa  = {az, ay, ax};
        q.pb  = {bz, by, bx};
        return q;
    endfunction

    function automatic logic [31:0] rand_coord(input int shift);
        return 32'(signed'($urandom()) >>> shift);
    endfunction

    // random request, mostly a sphere placed near the segment
    function automatic query_t random_query();
        query_t q;
        int     sh;
        int     kind;
        kind = $urandom_range(9);
        sh = $urandom_range(31);
        for (int i = 0; i < 3; i++)
        begin
            q.pa[i] = rand_coord(sh);
            q.pb[i] = (kind == 0) ? q.pa[i] + rand_coord(28) : rand_coord(sh);
            q.ctr[i] = (kind < 7) ? q.pa[i] + rand_coord(sh + 1 > 31 ? 31 : sh + 1)
                                  : rand_coord(0);
        end
        if (kind >= 8)
            q.rad = 31'($urandom());
        else
            q.rad = 31'($urandom() >> (sh + 1 > 31 ? 31 : sh + 1));
        return q;
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed_geometry();
        // zero segment, short segment
        send_request(make_query(32'h0001_0000, 0, 0, 31'h0001_0000, 5, 5, 5, 5, 5, 5));
        send_request(make_query(0, 0, 0, 31'h0001_0000, 0, 0, 0, 32'd300, 32'd300, 0));
        // crossing, centre between A and B
        send_request(make_query(32'h0005_0000, 32'h0001_0000, 0, 31'h0002_0000,
                                0, 0, 0, 32'h000a_0000, 0, 0));
        // crossing, centre past B
        send_request(make_query(32'h000c_0000, 0, 0, 31'h0003_0000,
                                0, 0, 0, 32'h000a_0000, 0, 0));
        // misses, each with the foot inside the segment
        send_request(make_query(32'h0005_0000, 32'h0009_0000, 0, 31'h0001_0000,
                                0, 0, 0, 32'h000a_0000, 0, 0));
        send_request(make_query(32'hfffb_0000, 32'h0009_0000, 32'h0001_0000, 31'h0001_0000,
                                0, 0, 0, 32'h000a_0000, 32'h000a_0000, 0));
        send_request(make_query(32'h0014_0000, 32'h0009_0000, 0, 31'h0001_0000,
                                0, 0, 0, 32'h000a_0000, 0, 32'hfff0_0000));
        // zero radius, full radius
        send_request(make_query(32'h0005_0000, 0, 0, 31'd0, 0, 0, 0, 32'h000a_0000, 0, 0));
        send_request(make_query(0, 0, 0, LEN_MAX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        // far target saturates
        send_request(make_query(32'h7fff_0000, 32'h7fff_ffff, 32'h7fff_ffff, LEN_MAX,
                                32'h7000_0000, 32'h7000_0000, 32'h7000_0000,
                                32'h7800_0000, 32'h7800_0000, 32'h7800_0000));
        send_request(make_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, LEN_MAX,
                                32'h9000_0000, 32'h8800_0000, 32'h8000_0000,
                                32'h8800_0000, 32'h8000_0000, 32'h8000_0000));
        send_request(make_query(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, LEN_MAX,
                                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        // all ones and all zeros in every field
        send_request(make_query('1, '1, '1, '1, '1, '1, '1, '0, '0, '0));
        send_request(make_query('0, '0, '0, '0, '0, '0, '0, '1, '1, '1));
    endtask

    task automatic test_threshold_extremes();
        // a zero threshold still treats A == B as degenerate
        write_min_length('0);
        send_request(make_query(0, 0, 0, 31'd10, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7, 32'd7));
        send_request(make_query(0, 0, 0, 31'd10, 0, 0, 0, 32'd1, 0, 0));
        write_min_length(LEN_MAX);
        send_request(make_query(0, 0, 0, 31'd10, 0, 0, 0, 32'h7fff_0000, 0, 0));
        send_request(make_query(0, 0, 0, 31'd10, 32'h8000_0000, 32'h8000_0000, 0,
                                32'h7fff_ffff, 32'h7fff_ffff, 0));
        write_min_length(31'h5555_5555);
        send_request(make_query(0, 0, 0, 31'h0001_0000, 0, 0, 0, 32'h5555_5555, 0, 0));
        send_request(make_query(0, 0, 0, 31'h0001_0000, 0, 0, 0, 32'h5555_5554, 0, 0));
    endtask

    task automatic test_random_requests(input int snd, input int rcv, input int count,
                                        input logic [30:0] min_len);
        write_min_length(min_len);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        repeat (count)
            send_request(random_query());
    endtask

    // ---------------------------------------------------------------- checking

    // receiver stalls
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_targets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h", res_ch.target_x,
                             res_ch.target_y, res_ch.target_z);
            end
            else
            begin
                target_t exp_t;
                exp_t = pending_targets.pop_front();
                if (res_ch.target_x !== exp_t.tgt[0] || res_ch.target_y !== exp_t.tgt[1] ||
                    res_ch.target_z !== exp_t.tgt[2] || res_ch.hit !== exp_t.hit ||
                    res_ch.degenerate !== exp_t.degen)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h hit %b deg %b got %h %h %h hit %b deg %b",
                                 exp_t.tgt[0], exp_t.tgt[1], exp_t.tgt[2], exp_t.hit,
                                 exp_t.degen, res_ch.target_x, res_ch.target_y,
                                 res_ch.target_z, res_ch.hit, res_ch.degenerate);
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sphere_line_target_point_core");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        mismatches    = 0;
        quiet_cycles  = 0;
        send_idle_pct = 14;
        recv_idle_pct = 56;
        min_len_model = sltp_pkg::MIN_LEN_RESET;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.center_x <= '0;
        req_ch.center_y <= '0;
        req_ch.center_z <= '0;
        req_ch.radius   <= '0;
        req_ch.start_x  <= '0;
        req_ch.start_y  <= '0;
        req_ch.start_z  <= '0;
        req_ch.end_x    <= '0;
        req_ch.end_y    <= '0;
        req_ch.end_z    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_geometry();
        test_threshold_extremes();
        test_random_requests(14, 56, 170, sltp_pkg::MIN_LEN_RESET);
        test_random_requests(56, 14, 170, 31'($urandom_range(65535)));
        test_random_requests(0, 0, 170, '0);

        drain_pipeline();
        if (mismatches == 0)
            $display("PASS sphere_line_target_point_core");
        else
            $display("FAIL sphere_line_target_point_core");
        $finish;
    end

endmodule
